// ===== src/utf8d_pkg.sv =====
// shared types, constants and byte bounds for the utf-8 validating decoder
package utf8d_pkg;

    localparam int COUNT_BITS_DEF = 20;
    localparam int RUNE_OUT_W     = 20;
    localparam int CODE_W         = 21;
    localparam int LIMIT_W        = 20;

    localparam logic [RUNE_OUT_W-1:0] COUNT_OUT_MAX = 20'hFFFFF;
    localparam logic [CODE_W-1:0]     CODE_MAX      = 21'h10FFFF;
    localparam logic [CODE_W-1:0]     SURR_LO       = 21'h00D800;
    localparam logic [CODE_W-1:0]     SURR_HI       = 21'h00DFFF;

    // lead byte classes
    localparam logic [7:0] ASCII_HI  = 8'h7F;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;

    // leads with narrowed second byte bounds
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F4   = 8'hF4;

    // continuation bounds
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] CONT_LO_E0  = 8'hA0;
    localparam logic [7:0] CONT_HI_ED  = 8'h9F;
    localparam logic [7:0] CONT_LO_F0  = 8'h90;
    localparam logic [7:0] CONT_HI_F4  = 8'h8F;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_TRUNC   = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        bytes_left;
        logic [CODE_W-1:0] code_accum;
        logic [7:0]        lead_value;
        logic              at_second_byte;
        logic              discarding;
    } seq_state_t;

    typedef struct packed {
        logic                  emit;
        logic [CODE_W-1:0]     code_point;
        status_t               status;
        logic [RUNE_OUT_W-1:0] rune_count;
        logic                  buffer_done;
    } result_t;

endpackage

// ===== src/utf8d_in_stage.sv =====
// input register stage: holds one accepted byte item until the decode step takes it
module utf8d_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  utf8d_pkg::in_item_t in_item,
    input  logic                advance,
    output logic                held_valid,
    output utf8d_pkg::in_item_t held_item
);

    logic                valid_reg;
    logic                valid_next;
    utf8d_pkg::in_item_t item_reg;

    // take a new item when empty or when the held one moves on
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ===== src/utf8d_step.sv =====
// decode step: sequence checks, next sequence state, rune count and result
module utf8d_step #(
    parameter int COUNT_BITS = utf8d_pkg::COUNT_BITS_DEF
) (
    input  utf8d_pkg::in_item_t               item,
    input  utf8d_pkg::seq_state_t             st,
    input  logic [COUNT_BITS-1:0]             rune_total,
    input  logic [utf8d_pkg::LIMIT_W-1:0]     max_runes,
    output utf8d_pkg::seq_state_t             st_next,
    output logic [COUNT_BITS-1:0]             rune_total_next,
    output utf8d_pkg::result_t                res
);

    localparam int CMP_W = (COUNT_BITS > utf8d_pkg::LIMIT_W) ? COUNT_BITS
                                                             : utf8d_pkg::LIMIT_W;
    localparam logic [COUNT_BITS-1:0] SAT = {COUNT_BITS{1'b1}};

    logic [7:0]                     b;
    logic                           skip;
    logic [7:0]                     lo;
    logic [7:0]                     hi;
    logic [utf8d_pkg::CODE_W-1:0]   acc_shift;
    logic [COUNT_BITS-1:0]          rt_inc;
    logic [COUNT_BITS-1:0]          rt_after;

    assign b         = item.byte_val;
    assign skip      = st.discarding ||
                       ((max_runes != '0) &&
                        (CMP_W'(rune_total) >= CMP_W'(max_runes)));
    assign acc_shift = {st.code_accum[utf8d_pkg::CODE_W-7:0], b[5:0]};
    assign rt_inc    = (rune_total == SAT) ? rune_total : rune_total + 1'b1;

    // second byte bounds depend on the lead
    always_comb
    begin
        lo = utf8d_pkg::CONT_LO;
        hi = utf8d_pkg::CONT_HI;
        if (st.at_second_byte)
        begin
            unique case (st.lead_value)
                utf8d_pkg::LEAD_E0: lo = utf8d_pkg::CONT_LO_E0;
                utf8d_pkg::LEAD_ED: hi = utf8d_pkg::CONT_HI_ED;
                utf8d_pkg::LEAD_F0: lo = utf8d_pkg::CONT_LO_F0;
                utf8d_pkg::LEAD_F4: hi = utf8d_pkg::CONT_HI_F4;
                default:
                begin
                    lo = utf8d_pkg::CONT_LO;
                    hi = utf8d_pkg::CONT_HI;
                end
            endcase
        end
    end

    always_comb
    begin
        st_next         = st;
        rt_after        = rune_total;
        res.emit        = 1'b0;
        res.code_point  = '0;
        res.status      = utf8d_pkg::STATUS_OK;
        res.buffer_done = item.last;
        if (!skip)
        begin
            if (st.bytes_left == 2'd0)
            begin
                if (b <= utf8d_pkg::ASCII_HI)
                begin
                    rt_after       = rt_inc;
                    res.emit       = 1'b1;
                    res.code_point = utf8d_pkg::CODE_W'(b);
                end
                else if (b >= utf8d_pkg::LEAD2_LO && b <= utf8d_pkg::LEAD2_HI)
                begin
                    st_next.bytes_left     = 2'd1;
                    st_next.code_accum     = utf8d_pkg::CODE_W'(b[4:0]);
                    st_next.lead_value     = b;
                    st_next.at_second_byte = 1'b1;
                end
                else if (b >= utf8d_pkg::LEAD3_LO && b <= utf8d_pkg::LEAD3_HI)
                begin
                    st_next.bytes_left     = 2'd2;
                    st_next.code_accum     = utf8d_pkg::CODE_W'(b[3:0]);
                    st_next.lead_value     = b;
                    st_next.at_second_byte = 1'b1;
                end
                else if (b >= utf8d_pkg::LEAD4_LO && b <= utf8d_pkg::LEAD4_HI)
                begin
                    st_next.bytes_left     = 2'd3;
                    st_next.code_accum     = utf8d_pkg::CODE_W'(b[2:0]);
                    st_next.lead_value     = b;
                    st_next.at_second_byte = 1'b1;
                end
                else
                begin
                    res.emit           = 1'b1;
                    res.status         = utf8d_pkg::STATUS_INVALID;
                    st_next.discarding = 1'b1;
                end
            end
            else if (b >= lo && b <= hi)
            begin
                st_next.bytes_left     = st.bytes_left - 2'd1;
                st_next.at_second_byte = 1'b0;
                if (st.bytes_left == 2'd1)
                begin
                    rt_after           = rt_inc;
                    res.emit           = 1'b1;
                    res.code_point     = acc_shift;
                    st_next.code_accum = '0;
                    st_next.lead_value = '0;
                end
                else
                begin
                    st_next.code_accum = acc_shift;
                end
            end
            else
            begin
                res.emit               = 1'b1;
                res.status             = utf8d_pkg::STATUS_INVALID;
                st_next.discarding     = 1'b1;
                st_next.bytes_left     = 2'd0;
                st_next.code_accum     = '0;
                st_next.lead_value     = '0;
                st_next.at_second_byte = 1'b0;
            end
            // buffer ends inside an open sequence
            if (item.last && !res.emit && st_next.bytes_left != 2'd0)
            begin
                res.emit   = 1'b1;
                res.status = utf8d_pkg::STATUS_TRUNC;
            end
        end
        if (item.last)
        begin
            st_next = '0;
        end
        // shown count is clamped to the output width
        res.rune_count = (CMP_W'(rt_after) > CMP_W'(utf8d_pkg::COUNT_OUT_MAX))
                         ? utf8d_pkg::COUNT_OUT_MAX
                         : utf8d_pkg::RUNE_OUT_W'(rt_after);
    end

    assign rune_total_next = item.last ? '0 : rt_after;

endmodule

// ===== src/utf8_validating_decoder.sv =====
// top level of the utf-8 validating decoder: input stage, decode step, result register
//
// usage
//   input channel: one byte item per handshake (byte_in, end_of_buffer) on
//   in_valid / in_ready; end_of_buffer marks the final byte of a buffer
//   output channel: at most one result item per byte (code_point, status,
//   rune_count, buffer_done) on out_valid / out_ready
//   max_runes is written through max_runes_we / max_runes_wdata while idle;
//   zero means no rune limit per buffer
// path: an accepted byte is held in the input register, decoded by combinational
//   logic between the input register and the result register, and stored there
// throughput: one byte per cycle while out_ready stays high; bytes that
//   give no result (lead and middle bytes, dropped bytes) still pass
//   through the decode stage
// reset: clears the sequence state, rune count, limit and both valid flags;
//   in_ready is high from reset on, so the first byte can be taken at once
// stall: with out_ready low and a result held, the decode stage waits and
//   the input register fills, then in_ready drops; nothing is lost
module utf8_validating_decoder #(
    parameter int COUNT_BITS = utf8d_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      byte_in,
    input  logic                            end_of_buffer,
    // configuration
    input  logic                            max_runes_we,
    input  logic [utf8d_pkg::LIMIT_W-1:0]   max_runes_wdata,
    // output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [utf8d_pkg::CODE_W-1:0]    code_point,
    output logic [1:0]                      status,
    output logic [utf8d_pkg::RUNE_OUT_W-1:0] rune_count,
    output logic                            buffer_done
);

    utf8d_pkg::in_item_t              in_item;
    utf8d_pkg::in_item_t              held_item;
    logic                             held_valid;
    logic                             advance;

    // sequence state and rune counter
    utf8d_pkg::seq_state_t            seq_reg;
    utf8d_pkg::seq_state_t            seq_next;
    logic [COUNT_BITS-1:0]            rune_total_reg;
    logic [COUNT_BITS-1:0]            rune_total_next;
    logic [utf8d_pkg::LIMIT_W-1:0]    max_runes_reg;

    // result register
    utf8d_pkg::result_t               res;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [utf8d_pkg::CODE_W-1:0]     code_point_reg;
    utf8d_pkg::status_t               status_reg;
    logic [utf8d_pkg::RUNE_OUT_W-1:0] rune_count_reg;
    logic                             buffer_done_reg;

    assign in_item.byte_val = byte_in;
    assign in_item.last     = end_of_buffer;

    // the held byte moves on when the result register is free or being drained
    assign advance = held_valid && (!out_valid_reg || out_ready);

    utf8d_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    utf8d_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .item            (held_item),
        .st              (seq_reg),
        .rune_total      (rune_total_reg),
        .max_runes       (max_runes_reg),
        .st_next         (seq_next),
        .rune_total_next (rune_total_next),
        .res             (res)
    );

    // limit register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_runes_reg <= '0;
        end
        else if (max_runes_we)
        begin
            max_runes_reg <= max_runes_wdata;
        end
    end

    // per-buffer state advances once per decoded byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg        <= '0;
            rune_total_reg <= '0;
        end
        else if (advance)
        begin
            seq_reg        <= seq_next;
            rune_total_reg <= rune_total_next;
        end
    end

    // result valid: load on a decoded byte, clear once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res.emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
        begin
            code_point_reg  <= res.code_point;
            status_reg      <= res.status;
            rune_count_reg  <= res.rune_count;
            buffer_done_reg <= res.buffer_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_point  = code_point_reg;
    assign status      = status_reg;
    assign rune_count  = rune_count_reg;
    assign buffer_done = buffer_done_reg;

endmodule

// ===== src/utf8d_checker.sv =====
// port-level checks for the utf-8 validating decoder, bound to the top level
module utf8d_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [utf8d_pkg::CODE_W-1:0]     code_point,
    input logic [1:0]                       status,
    input logic                             buffer_done
);

    // a held result keeps its code point and status
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(status))
        else $error("result changed while stalled");

    // only decoded runes carry a code point
    a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != utf8d_pkg::STATUS_OK |-> code_point == '0)
        else $error("code point set on an error result");

    // a decoded rune is a scalar value
    a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == utf8d_pkg::STATUS_OK |->
            code_point <= utf8d_pkg::CODE_MAX &&
            !(code_point >= utf8d_pkg::SURR_LO && code_point <= utf8d_pkg::SURR_HI))
        else $error("decoded value is not a scalar value");

    // a truncated result only comes from the final byte
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == utf8d_pkg::STATUS_TRUNC |-> buffer_done)
        else $error("truncated result before end of buffer");

endmodule

bind utf8_validating_decoder utf8d_checker u_utf8d_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .status      (status),
    .buffer_done (buffer_done)
);

// ===== test/tb_utf8_validating_decoder.sv =====
// self-checking testbench for the utf-8 validating decoder, with its own byte-level predictor
`timescale 1ns / 100ps

import utf8d_pkg::*;

// one decoded result as the block should present it
typedef struct packed {
    logic [CODE_W-1:0]     code_point;
    status_t               status;
    logic [RUNE_OUT_W-1:0] rune_count;
    logic                  buffer_done;
} decoded_t;

// predicts the result of every accepted byte and checks the block's results in order
class rune_scoreboard;
    logic [LIMIT_W-1:0]    limit;
    logic [1:0]            cont_left;
    logic [CODE_W-1:0]     accum;
    logic [7:0]            lead;
    bit                    second_next;
    logic [RUNE_OUT_W-1:0] runes;
    bit                    dropping;
    decoded_t              pending_runes[$];
    int unsigned           errors;
    int unsigned           bytes_seen;
    int unsigned           live_bytes;
    int unsigned           n_rune;
    int unsigned           n_invalid;
    int unsigned           n_trunc;

    function new();
        limit      = '0;
        errors     = 0;
        bytes_seen = 0;
        live_bytes = 0;
        n_rune     = 0;
        n_invalid  = 0;
        n_trunc    = 0;
        clear_buffer();
    endfunction

    function void clear_buffer();
        cont_left   = '0;
        accum       = '0;
        lead        = '0;
        second_next = 1'b0;
        runes       = '0;
        dropping    = 1'b0;
    endfunction

    function decoded_t outcome(logic [CODE_W-1:0] cp, status_t st, logic last);
        decoded_t r;
        r.code_point  = cp;
        r.status      = st;
        r.rune_count  = runes;
        r.buffer_done = last;
        return r;
    endfunction

    // note one accepted byte and queue the result it causes, if any
    function void take_byte(logic [7:0] b, logic last);
        logic [7:0] lo;
        logic [7:0] hi;
        bit         made;
        decoded_t   r;
        made = 1'b0;
        bytes_seen++;
        // after an error or once the rune limit is met, bytes vanish silently
        if (dropping || (limit != 0 && runes >= limit))
        begin
            if (last)
                clear_buffer();
            return;
        end
        live_bytes++;
        if (cont_left == 0)
        begin
            if (b <= ASCII_HI)
            begin
                if (runes != '1)
                    runes++;
                r    = outcome(CODE_W'(b), STATUS_OK, last);
                made = 1'b1;
            end
            else if (b >= LEAD2_LO && b <= LEAD2_HI)
            begin
                cont_left = 2'd1;
                accum     = CODE_W'(b[4:0]);
            end
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                cont_left = 2'd2;
                accum     = CODE_W'(b[3:0]);
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                cont_left = 2'd3;
                accum     = CODE_W'(b[2:0]);
            end
            else
            begin
                r        = outcome('0, STATUS_INVALID, last);
                dropping = 1'b1;
                made     = 1'b1;
            end
            if (cont_left != 0)
            begin
                lead        = b;
                second_next = 1'b1;
            end
        end
        else
        begin
            lo = CONT_LO;
            hi = CONT_HI;
            if (second_next)
            begin
                case (lead)
                    LEAD_E0: lo = CONT_LO_E0;
                    LEAD_ED: hi = CONT_HI_ED;
                    LEAD_F0: lo = CONT_LO_F0;
                    LEAD_F4: hi = CONT_HI_F4;
                    default: ;
                endcase
            end
            if (b >= lo && b <= hi)
            begin
                accum       = {accum[CODE_W-7:0], b[5:0]};
                cont_left   = cont_left - 2'd1;
                second_next = 1'b0;
                if (cont_left == 0)
                begin
                    if (runes != '1)
                        runes++;
                    r     = outcome(accum, STATUS_OK, last);
                    accum = '0;
                    lead  = '0;
                    made  = 1'b1;
                end
            end
            else
            begin
                r           = outcome('0, STATUS_INVALID, last);
                dropping    = 1'b1;
                cont_left   = '0;
                accum       = '0;
                lead        = '0;
                second_next = 1'b0;
                made        = 1'b1;
            end
        end
        if (last)
        begin
            // a sequence still open on the final byte is reported as cut short
            if (!made && cont_left != 0)
            begin
                r    = outcome('0, STATUS_TRUNC, 1'b1);
                made = 1'b1;
            end
            clear_buffer();
        end
        if (made)
        begin
            case (r.status)
                STATUS_OK:      n_rune++;
                STATUS_INVALID: n_invalid++;
                default:        n_trunc++;
            endcase
            pending_runes.push_back(r);
        end
    endfunction

    task report(string what);
        errors++;
        if (errors <= 40)
            $display("ERROR: %s", what);
    endtask

    // compare one result taken from the block with the oldest prediction
    task check_rune(logic [CODE_W-1:0] cp, logic [1:0] st, logic [RUNE_OUT_W-1:0] cnt,
                    logic done);
        decoded_t e;
        if (pending_runes.size() == 0)
        begin
            report($sformatf("unexpected result cp=%h status=%0d count=%0d done=%b",
                             cp, st, cnt, done));
            return;
        end
        e = pending_runes.pop_front();
        if (cp !== e.code_point)
            report($sformatf("code_point %h, expected %h", cp, e.code_point));
        if (st !== e.status)
            report($sformatf("status %0d, expected %0d", st, e.status));
        if (cnt !== e.rune_count)
            report($sformatf("rune_count %0d, expected %0d", cnt, e.rune_count));
        if (done !== e.buffer_done)
            report($sformatf("buffer_done %b, expected %b", done, e.buffer_done));
    endtask
endclass

module tb_utf8_validating_decoder;

    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_BYTES   = 110;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            byte_in;
    logic                  end_of_buffer;
    logic                  max_runes_we;
    logic [LIMIT_W-1:0]    max_runes_wdata;
    logic                  out_valid;
    logic                  out_ready;
    logic [CODE_W-1:0]     code_point;
    logic [1:0]            status;
    logic [RUNE_OUT_W-1:0] rune_count;
    logic                  buffer_done;

    rune_scoreboard decode_sb;
    bit             calm;
    int unsigned    cycle_count;
    int unsigned    limit_writes;
    logic [7:0]     buf_bytes[$];
    logic [7:0]     rune_bytes[$];

    utf8_validating_decoder i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .byte_in         (byte_in),
        .end_of_buffer   (end_of_buffer),
        .max_runes_we    (max_runes_we),
        .max_runes_wdata (max_runes_wdata),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .code_point      (code_point),
        .status          (status),
        .rune_count      (rune_count),
        .buffer_done     (buffer_done)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     decode_sb.pending_runes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // idle cycles before the next item on either side; none during calm stretches
    function automatic int unsigned draw_gap();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        byte_in       <= b;
        end_of_buffer <= last;
        do @(posedge clk); while (!in_ready);
        decode_sb.take_byte(b, last);
        @(negedge clk);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < buf_bytes.size(); i++)
            send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
    endtask

    // hold the sender until every predicted result has come out, then let the pipe empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (decode_sb.pending_runes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        wait_idle();
        max_runes_we    <= 1'b1;
        max_runes_wdata <= value;
        @(negedge clk);
        max_runes_we    <= 1'b0;
        decode_sb.limit = value;
        limit_writes++;
    endtask

    // one well-formed sequence with random content, leaning on the narrowed leads
    function automatic void make_rune();
        int unsigned kind;
        logic [7:0]  lead;
        logic [7:0]  lo;
        logic [7:0]  hi;
        rune_bytes.delete();
        kind = $urandom_range(0, 3);
        lo   = CONT_LO;
        hi   = CONT_HI;
        case (kind)
            0: rune_bytes.push_back(8'($urandom_range(0, 8'h7F)));
            1:
            begin
                rune_bytes.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
                rune_bytes.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
            end
            2:
            begin
                lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
                if ($urandom_range(0, 3) == 0)
                    lead = $urandom_range(0, 1) ? LEAD_E0 : LEAD_ED;
                if (lead == LEAD_E0)
                    lo = CONT_LO_E0;
                if (lead == LEAD_ED)
                    hi = CONT_HI_ED;
                rune_bytes.push_back(lead);
                rune_bytes.push_back(8'($urandom_range(lo, hi)));
                rune_bytes.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
            end
            default:
            begin
                lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
                if (lead == LEAD_F0)
                    lo = CONT_LO_F0;
                if (lead == LEAD_F4)
                    hi = CONT_HI_F4;
                rune_bytes.push_back(lead);
                rune_bytes.push_back(8'($urandom_range(lo, hi)));
                rune_bytes.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
                rune_bytes.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
            end
        endcase
    endfunction

    // mostly well-formed text, some noise bytes, some broken sequences, now and then
    // a buffer that stops inside a sequence
    function automatic void fill_buffer();
        int unsigned n_seq;
        int unsigned pick;
        int unsigned cut;
        buf_bytes.delete();
        n_seq = $urandom_range(1, 6);
        for (int s = 0; s < n_seq; s++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 90)
            begin
                make_rune();
                // a broken sequence: one byte replaced by anything
                if (pick >= 80)
                    rune_bytes[$urandom_range(0, rune_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
                foreach (rune_bytes[k])
                    buf_bytes.push_back(rune_bytes[k]);
            end
            else
            begin
                buf_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 9) == 0)
        begin
            do make_rune(); while (rune_bytes.size() < 2);
            cut = $urandom_range(1, rune_bytes.size() - 1);
            for (int k = 0; k < cut; k++)
                buf_bytes.push_back(rune_bytes[k]);
        end
    endfunction

    // result side: random back-pressure per item, checks everything it takes
    initial
    begin : result_sink
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = draw_gap();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            decode_sb.check_rune(code_point, status, rune_count, buffer_done);
        end
    end

    initial
    begin : stimulus
        logic [LIMIT_W-1:0] phase_limit[0:4];
        int unsigned        start;

        decode_sb       = new();
        calm            = 1'b0;
        cycle_count     = 0;
        limit_writes    = 0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        byte_in         = '0;
        end_of_buffer   = 1'b0;
        max_runes_we    = 1'b0;
        max_runes_wdata = '0;
        out_ready       = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extreme runes, narrowed second bytes, errors and cut buffers
        set_limit('0);
        buf_bytes = '{8'h00, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_buffer();
        // bad second byte after ed, then dropping through the final byte
        buf_bytes = '{8'hED, 8'hA0, 8'h41, 8'h80};
        send_buffer();
        // bad byte on the final byte, no truncation on top
        buf_bytes = '{8'hF0, 8'h8F};
        send_buffer();
        // buffer ends inside a sequence
        buf_bytes = '{8'hE1, 8'h80};
        send_buffer();
        buf_bytes = '{8'hC0};
        send_buffer();
        buf_bytes = '{8'hFF, 8'h41};
        send_buffer();
        // limit reached: the final byte is ignored as well
        set_limit(20'd1);
        buf_bytes = '{8'h41, 8'h42};
        send_buffer();
        // limit lowered in the middle of a buffer takes effect at once
        set_limit('0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        set_limit(20'd1);
        send_byte(8'h43, 1'b1);

        // random phases, each under its own rune limit
        phase_limit = '{20'hFFFFF, 20'd0, 20'd2, 20'($urandom_range(1, 6)), 20'd0};
        for (int p = 0; p < 5; p++)
        begin
            set_limit(phase_limit[p]);
            start = decode_sb.bytes_seen;
            while (decode_sb.bytes_seen - start < PHASE_BYTES)
            begin
                calm = ($urandom_range(0, 7) == 0);
                fill_buffer();
                send_buffer();
            end
            calm = 1'b0;
        end

        wait_idle();
        repeat (2 * SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d bytes (%0d decoded) under %0d limit settings",
                 decode_sb.bytes_seen, decode_sb.live_bytes, limit_writes);
        $display("results: %0d runes, %0d invalid, %0d truncated, with random stalls",
                 decode_sb.n_rune, decode_sb.n_invalid, decode_sb.n_trunc);
        if (decode_sb.errors == 0 && decode_sb.pending_runes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
